>>> hdl/vrsr_pkg.sv
// Shared constants, register codes and divider handshake types for the velocity ramp unit.
package vrsr_pkg;

  localparam int unsigned VEL_W = 28;
  localparam int unsigned ACC_W = 30;
  localparam int unsigned DT_W = 32;
  localparam int unsigned RATE_WORD_BITS_DEF = 24;

  localparam int unsigned PROD_W = DT_W + ACC_W;
  localparam int unsigned STEP_SAT_BIT = 48;
  localparam int unsigned DV_W = 29;
  localparam int unsigned MULT_W = 26;
  localparam int unsigned RQ_W = 24;

  localparam int unsigned DIVIDEND_W = 56;
  localparam int unsigned DIVISOR_W = 30;
  localparam int unsigned DIV_STEP_BITS = 4;
  localparam int unsigned DIV_DIGITS = DIVIDEND_W / DIV_STEP_BITS;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_DIGITS + 1);

  localparam logic [MULT_W-1:0] RATE_MULT = 26'd57266230;
  localparam logic [DIVISOR_W-1:0] US_PER_SEC = 30'd1000000;
  localparam logic [DIVISOR_W-1:0] RATE_DIVISOR = 30'd1000000000;
  localparam logic [DIVISOR_W-1:0] RATE_HALF = 30'd500000000;

  localparam int unsigned FIFO_DEPTH = 2;

  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;

  typedef enum logic [1:0] {
    REG_TARGET_VEL = 2'd0,
    REG_TRACK_EN   = 2'd1,
    REG_TRACK_RATE = 2'd2,
    REG_ACCEL      = 2'd3
  } vrsr_reg_e;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } vrsr_div_req_t;

  typedef struct packed {
    logic                  busy;
    logic [DIVIDEND_W-1:0] quotient;
  } vrsr_div_rsp_t;

endpackage

>>> hdl/velocity_ramp_to_stepper_rate_unit.sv
// Top level of the velocity ramp unit: register file, front, queue, back and divider.
// Each nonzero tick moves the kept velocity toward the target by elapsed_us * acceleration
// / 1e6 (clamped at the target) and yields one item carrying the new velocity and the
// saturated stepper rate word round(velocity * 57266230 / 1e9). A tick whose elapsed time
// is zero, or that finds the velocity already at the target, yields nothing. An item that
// yields a result holds the back end through two passes of the one shared radix-16 divider
// and until the output register is free; a skipped tick leaves from the idle state. A two-entry
// queue and an output register let ticks be taken while a result waits. Configuration
// registers sit at byte offsets 0, 4, 8 and 12 and are to be written while no tick is in flight.
module velocity_ramp_to_stepper_rate_unit #(
  parameter int unsigned RATE_WORD_BITS = vrsr_pkg::RATE_WORD_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [vrsr_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [vrsr_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [vrsr_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [vrsr_pkg::DT_W-1:0]           elapsed_us_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [RATE_WORD_BITS-1:0]    rate_word_o,
  output logic signed [vrsr_pkg::VEL_W-1:0]   velocity_now_o
);
  import vrsr_pkg::*;

  logic signed [VEL_W-1:0] tgt_q;
  logic                    trk_en_q;
  logic signed [VEL_W-1:0] trk_rate_q;
  logic [ACC_W-1:0]        acc_q;
  logic signed [VEL_W-1:0] target;
  vrsr_reg_e               reg_sel;
  logic                    wr_en;

  logic            push_valid;
  logic            push_ready;
  logic [DT_W-1:0] push_dt;
  logic            pop_valid;
  logic            pop_ready;
  logic [DT_W-1:0] pop_dt;
  vrsr_div_req_t   div_req;
  vrsr_div_rsp_t   div_rsp;

  assign pready  = 1'b1;
  assign reg_sel = vrsr_reg_e'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_q      <= '0;
      trk_en_q   <= 1'b0;
      trk_rate_q <= '0;
      acc_q      <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        REG_TARGET_VEL: tgt_q      <= pwdata[VEL_W-1:0];
        REG_TRACK_EN:   trk_en_q   <= pwdata[0];
        REG_TRACK_RATE: trk_rate_q <= pwdata[VEL_W-1:0];
        REG_ACCEL:      acc_q      <= pwdata[ACC_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_TARGET_VEL: prdata = APB_DATA_W'(unsigned'(tgt_q));
      REG_TRACK_EN:   prdata = APB_DATA_W'(trk_en_q);
      REG_TRACK_RATE: prdata = APB_DATA_W'(unsigned'(trk_rate_q));
      REG_ACCEL:      prdata = APB_DATA_W'(acc_q);
      default:        prdata = '0;
    endcase
  end

  assign target = (trk_en_q && tgt_q == '0) ? trk_rate_q : tgt_q;

  vrsr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .elapsed_us_i (elapsed_us_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_dt_o    (push_dt)
  );

  vrsr_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_dt_i    (push_dt),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_dt_o     (pop_dt)
  );

  vrsr_cdiv u_cdiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  vrsr_back #(
    .RATE_WORD_BITS (RATE_WORD_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pop_valid_i    (pop_valid),
    .pop_ready_o    (pop_ready),
    .pop_dt_i       (pop_dt),
    .target_i       (target),
    .accel_i        (acc_q),
    .div_req_o      (div_req),
    .div_rsp_i      (div_rsp),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .rate_word_o    (rate_word_o),
    .velocity_now_o (velocity_now_o)
  );

endmodule

>>> hdl/vrsr_front.sv
// Front stage: take tick items, drop zero-length ticks, hand the rest to the queue.
module vrsr_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [vrsr_pkg::DT_W-1:0]  elapsed_us_i,
  output logic                       push_valid_o,
  input  logic                       push_ready_i,
  output logic [vrsr_pkg::DT_W-1:0]  push_dt_o
);
  import vrsr_pkg::*;

  logic            slot_vld_q;
  logic [DT_W-1:0] slot_dt_q;
  logic            take;

  assign in_ready_o   = !slot_vld_q || push_ready_i;
  assign take         = in_valid_i && in_ready_o;
  assign push_valid_o = slot_vld_q;
  assign push_dt_o    = slot_dt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_vld_q <= 1'b0;
    end else if (take) begin
      slot_vld_q <= (elapsed_us_i != '0);
    end else if (push_ready_i) begin
      slot_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      slot_dt_q <= elapsed_us_i;
    end
  end

endmodule

>>> hdl/vrsr_fifo.sv
// Short queue of tick lengths between the front and the back.
module vrsr_fifo (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_valid_i,
  output logic                       push_ready_o,
  input  logic [vrsr_pkg::DT_W-1:0]  push_dt_i,
  output logic                       pop_valid_o,
  input  logic                       pop_ready_i,
  output logic [vrsr_pkg::DT_W-1:0]  pop_dt_o
);
  import vrsr_pkg::*;

  localparam int unsigned PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

  logic [DT_W-1:0]  mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wptr_q;
  logic [PTR_W-1:0] rptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push;
  logic             do_pop;

  assign push_ready_o = (cnt_q != CNT_W'(FIFO_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_dt_o     = mem_q[rptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_dt_i;
    end
  end

endmodule

>>> hdl/vrsr_cdiv.sv
// Shared radix-16 restoring divider, four quotient bits per cycle.
module vrsr_cdiv (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  vrsr_pkg::vrsr_div_req_t req_i,
  output vrsr_pkg::vrsr_div_rsp_t rsp_o
);
  import vrsr_pkg::*;

  logic [DIV_CNT_W-1:0]  cnt_q;
  logic [DIVISOR_W-1:0]  rem_q;
  logic [DIVISOR_W-1:0]  rem_n;
  logic [DIVIDEND_W-1:0] dq_q;
  logic [DIVIDEND_W-1:0] dq_n;
  logic [DIVISOR_W-1:0]  dvsr_q;

  always_comb begin
    logic [DIVISOR_W:0] trial;
    rem_n = rem_q;
    dq_n  = dq_q;
    trial = '0;
    for (int k = 0; k < DIV_STEP_BITS; k++) begin
      trial = {rem_n, dq_n[DIVIDEND_W-1]};
      dq_n  = {dq_n[DIVIDEND_W-2:0], 1'b0};
      if (trial >= {1'b0, dvsr_q}) begin
        rem_n   = DIVISOR_W'(trial - {1'b0, dvsr_q});
        dq_n[0] = 1'b1;
      end else begin
        rem_n = trial[DIVISOR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (req_i.start) begin
      cnt_q <= DIV_CNT_W'(DIV_DIGITS);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= '0;
      dq_q   <= req_i.dividend;
      dvsr_q <= req_i.divisor;
    end else if (cnt_q != '0) begin
      rem_q <= rem_n;
      dq_q  <= dq_n;
    end
  end

  assign rsp_o.busy     = (cnt_q != '0);
  assign rsp_o.quotient = dq_q;

endmodule

>>> hdl/vrsr_back.sv
// Back stage: ramp the kept velocity toward the target and form the stepper rate word.
module vrsr_back #(
  parameter int unsigned RATE_WORD_BITS = vrsr_pkg::RATE_WORD_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              pop_valid_i,
  output logic                              pop_ready_o,
  input  logic [vrsr_pkg::DT_W-1:0]         pop_dt_i,
  input  logic signed [vrsr_pkg::VEL_W-1:0] target_i,
  input  logic [vrsr_pkg::ACC_W-1:0]        accel_i,
  output vrsr_pkg::vrsr_div_req_t           div_req_o,
  input  vrsr_pkg::vrsr_div_rsp_t           div_rsp_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [RATE_WORD_BITS-1:0]  rate_word_o,
  output logic signed [vrsr_pkg::VEL_W-1:0] velocity_now_o
);
  import vrsr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_STEP_GO,
    S_STEP_WAIT,
    S_UPDATE,
    S_SCALE,
    S_RATE_GO,
    S_RATE_WAIT,
    S_OUT
  } state_e;

  localparam int unsigned SW = 33;
  localparam logic [SW-1:0] RMAX = (SW'(1) << (RATE_WORD_BITS - 1)) - SW'(1);

  state_e                      state_q;
  logic signed [VEL_W-1:0]     cur_q;
  logic [PROD_W-1:0]           prod_q;
  logic                        neg_q;
  logic                        out_vld_q;
  logic [RATE_WORD_BITS-1:0]   out_rate_q;
  logic [VEL_W-1:0]            out_vel_q;

  logic                        at_target;
  logic [PROD_W-1:0]           step_prod;
  logic [PROD_W-1:0]           scale_prod;
  logic [VEL_W-1:0]            mag;
  logic                        step_sat;
  logic [DV_W-1:0]             dv;
  logic signed [VEL_W+2:0]     cur_x;
  logic signed [VEL_W+2:0]     tgt_x;
  logic signed [VEL_W+2:0]     nv_dn;
  logic signed [VEL_W+2:0]     nv_up;
  logic signed [VEL_W-1:0]     cur_new;
  logic [SW-1:0]               qx;
  logic [SW-1:0]               rsel;
  logic                        out_free;

  assign at_target  = (cur_q == target_i);
  assign step_prod  = PROD_W'(pop_dt_i) * PROD_W'(accel_i);
  assign mag        = cur_q[VEL_W-1] ? (~cur_q + VEL_W'(1)) : cur_q;
  assign scale_prod = PROD_W'(mag) * PROD_W'(RATE_MULT);
  assign step_sat   = (prod_q[PROD_W-1:STEP_SAT_BIT] != '0);
  assign dv         = step_sat ? '1 : div_rsp_i.quotient[DV_W-1:0];

  assign cur_x = (VEL_W+3)'(cur_q);
  assign tgt_x = (VEL_W+3)'(target_i);
  assign nv_dn = cur_x - $signed({2'b00, dv});
  assign nv_up = cur_x + $signed({2'b00, dv});

  always_comb begin
    if (target_i < cur_q) begin
      cur_new = (nv_dn > tgt_x) ? nv_dn[VEL_W-1:0] : target_i;
    end else begin
      cur_new = (nv_up < tgt_x) ? nv_up[VEL_W-1:0] : target_i;
    end
  end

  assign qx = SW'(div_rsp_i.quotient[RQ_W-1:0]);

  always_comb begin
    if (!neg_q) begin
      rsel = (qx > RMAX) ? RMAX : qx;
    end else begin
      rsel = (qx > RMAX + SW'(1)) ? ~RMAX : (~qx + SW'(1));
    end
  end

  assign out_free    = !out_vld_q || out_ready_i;
  assign pop_ready_o = (state_q == S_IDLE);

  always_comb begin
    div_req_o.start    = (state_q == S_STEP_GO) || (state_q == S_RATE_GO);
    div_req_o.dividend = DIVIDEND_W'(prod_q[STEP_SAT_BIT-1:0]);
    div_req_o.divisor  = US_PER_SEC;
    if (state_q == S_RATE_GO) begin
      div_req_o.dividend = DIVIDEND_W'(prod_q) + DIVIDEND_W'(RATE_HALF);
      div_req_o.divisor  = RATE_DIVISOR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cur_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (state_q == S_OUT && out_free) begin
        out_vld_q <= 1'b1;
      end else if (out_vld_q && out_ready_i) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (pop_valid_i && !at_target) begin
            state_q <= S_STEP_GO;
          end
        end
        S_STEP_GO: begin
          state_q <= S_STEP_WAIT;
        end
        S_STEP_WAIT: begin
          if (!div_rsp_i.busy) begin
            state_q <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          cur_q   <= cur_new;
          state_q <= S_SCALE;
        end
        S_SCALE: begin
          state_q <= S_RATE_GO;
        end
        S_RATE_GO: begin
          state_q <= S_RATE_WAIT;
        end
        S_RATE_WAIT: begin
          if (!div_rsp_i.busy) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && pop_valid_i) begin
      prod_q <= step_prod;
    end
    if (state_q == S_SCALE) begin
      prod_q <= scale_prod;
      neg_q  <= cur_q[VEL_W-1];
    end
    if (state_q == S_OUT && out_free) begin
      out_rate_q <= rsel[RATE_WORD_BITS-1:0];
      out_vel_q  <= cur_q;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign rate_word_o    = out_rate_q;
  assign velocity_now_o = out_vel_q;

endmodule

>>> hdl/vrsr_chk.sv
// Port-level checker for the velocity ramp unit and its bind to the top level.
module vrsr_chk #(
  parameter int unsigned RATE_WORD_BITS = vrsr_pkg::RATE_WORD_BITS_DEF
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              pready,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic signed [RATE_WORD_BITS-1:0]  rate_word_o,
  input logic signed [vrsr_pkg::VEL_W-1:0] velocity_now_o
);
  import vrsr_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(rate_word_o) && $stable(velocity_now_o))
    else $error("result item changed while stalled");

  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("result item shown during reset");

  a_pready: assert property (@(posedge clk_i) pready)
    else $error("pready dropped");

  a_sign_neg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && velocity_now_o[VEL_W-1] |->
      rate_word_o[RATE_WORD_BITS-1] || rate_word_o == '0)
    else $error("negative velocity with positive rate word");

  a_sign_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !velocity_now_o[VEL_W-1] |-> !rate_word_o[RATE_WORD_BITS-1])
    else $error("non-negative velocity with negative rate word");

endmodule

bind velocity_ramp_to_stepper_rate_unit vrsr_chk #(
  .RATE_WORD_BITS (RATE_WORD_BITS)
) u_vrsr_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .pready         (pready),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .rate_word_o    (rate_word_o),
  .velocity_now_o (velocity_now_o)
);
